// ===== rtl/vertex_normal_accumulator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define VNA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define VNA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Word formats, operation codes and fixed widths shared by the block.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int VIDX_WIDTH  = 10;
   localparam int FIELD_WIDTH = 16;
   localparam int ACC_WIDTH   = 48;
   localparam int RECIP_SHIFT = 20;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_TRIANGLE = 2'd1,
      OP_READ     = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type                    opcode;
      logic [VIDX_WIDTH-1:0]         vertex_index;
      logic signed [FIELD_WIDTH-1:0] pos_x;
      logic signed [FIELD_WIDTH-1:0] pos_y;
      logic signed [FIELD_WIDTH-1:0] pos_z;
      logic [VIDX_WIDTH-1:0]         corner_a;
      logic [VIDX_WIDTH-1:0]         corner_b;
      logic [VIDX_WIDTH-1:0]         corner_c;
   } req_word_type;

   typedef struct packed {
      logic [VIDX_WIDTH-1:0]         out_vertex;
      logic signed [FIELD_WIDTH-1:0] norm_x;
      logic signed [FIELD_WIDTH-1:0] norm_y;
      logic signed [FIELD_WIDTH-1:0] norm_z;
      logic                          is_zero;
   } rsp_word_type;

   typedef struct packed {
      logic [ACC_WIDTH-1:0] x;
      logic [ACC_WIDTH-1:0] y;
      logic [ACC_WIDTH-1:0] z;
   } acc_vec_type;

endpackage

// ===== rtl/vna_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface vna_req_if import vna_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/vna_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one response word.
// ----------------------------------------------------------------------------
interface vna_rsp_if import vna_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/vertex_normal_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Face-weighted smooth vertex normals for an indexed triangle list.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Word
// req_ch   in   valid/ready          opcode, index, position, corners
// rsp_ch   out  valid/ready          vertex, Q1.14 normal, zero flag
//
// The front end takes a new word only after pushing the last one and wraps
// indices there. In the back end a triangle makes three position reads and
// three serial accumulator read-modify-writes on one port.
// A read runs through the normalize unit: up to 18 single-bit shift steps,
// a 32-step square root and three divisions; a zero normal skips them.
// Reset is synchronous; memories come up unwritten and need no clearing pass.
// A stalled response waits in the output register while later words proceed.
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_unit_defines.svh"

module vertex_normal_accumulator_unit import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int POS_WIDTH    = 16
) (
   input logic       clock,
   input logic       reset,
   vna_req_if.sink   req_ch,
   vna_rsp_if.source rsp_ch
);

   logic         q_push_valid;
   logic         q_push_ready;
   req_word_type q_in;
   logic         q_valid;
   logic         q_ready;
   req_word_type q_out;
   logic         q_push;
   logic         idx_wrapped;
   logic         zero_clean;

   assign q_push = q_push_valid && q_push_ready;

   assign idx_wrapped = (32'(q_in.vertex_index) < MAX_VERTICES) &&
                        (32'(q_in.corner_a) < MAX_VERTICES) &&
                        (32'(q_in.corner_b) < MAX_VERTICES) &&
                        (32'(q_in.corner_c) < MAX_VERTICES);
   assign zero_clean  = (rsp_ch.data.norm_x == 16'sd0) && (rsp_ch.data.norm_y == 16'sd0) &&
                        (rsp_ch.data.norm_z == 16'sd0);

   vna_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_in)
   );

   vna_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_in),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_out)
   );

   vna_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .POS_WIDTH    (POS_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_data  (q_out),
      .rsp     (rsp_ch)
   );

   `VNA_ASSERT_IMPL(a_no_unused_op, clock, reset, q_push, q_in.opcode != OP_NONE, "unused opcode queued")
   `VNA_ASSERT_IMPL(a_index_wrapped, clock, reset, q_push, idx_wrapped, "index not wrapped")
   `VNA_ASSERT_NEXT(a_queue_holds, clock, reset, q_push, q_valid, "queued word lost")
   `VNA_ASSERT_IMPL(a_zero_result, clock, reset, rsp_ch.valid && rsp_ch.data.is_zero, zero_clean, "zero normal not zero")

endmodule

// ===== rtl/vna_front.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator front end
// Accepts request words, drops unused opcodes and wraps every vertex index
// modulo the vertex count before handing the word to the queue.
// ----------------------------------------------------------------------------
module vna_front import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   vna_req_if.sink      req,
   output logic         push_valid,
   input  logic         push_ready,
   output req_word_type push_data
);

   localparam int             RECIP = (1 << RECIP_SHIFT) / MAX_VERTICES;
   localparam int             PRODW = VIDX_WIDTH + RECIP_SHIFT;
   localparam int             MW    = $clog2(MAX_VERTICES + 1) + 1;
   localparam int             RMW   = VIDX_WIDTH + MW;
   localparam logic [RECIP_SHIFT-1:0] RECIP_W = RECIP_SHIFT'(RECIP);
   localparam logic [MW-1:0]  MAXV  = MW'(MAX_VERTICES);

   typedef enum logic [2:0] {F_IDLE, F_QUOT, F_REM, F_FIX, F_PUSH} state_type;

   state_type             state_ff, state_in;
   req_word_type          item_ff;
   logic [VIDX_WIDTH-1:0] lane_v [4];
   logic [VIDX_WIDTH-1:0] q_ff [4];
   logic [VIDX_WIDTH-1:0] r_ff [4];
   logic [VIDX_WIDTH-1:0] fix_v [4];
   logic                  accept;

   assign req.ready  = (state_ff == F_IDLE);
   assign accept     = req.valid && req.ready;
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = item_ff;

   assign lane_v[0] = item_ff.vertex_index;
   assign lane_v[1] = item_ff.corner_a;
   assign lane_v[2] = item_ff.corner_b;
   assign lane_v[3] = item_ff.corner_c;

   // The reciprocal estimate is low by at most one, so one subtract fixes it.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (MW'(r_ff[i]) >= MAXV) begin
            fix_v[i] = VIDX_WIDTH'(MW'(r_ff[i]) - MAXV);
         end else begin
            fix_v[i] = r_ff[i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept && (req.data.opcode != OP_NONE)) begin
               state_in = F_QUOT;
            end
         end
         F_QUOT: state_in = F_REM;
         F_REM:  state_in = F_FIX;
         F_FIX:  state_in = F_PUSH;
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               item_ff <= req.data;
            end
         end
         F_QUOT: begin
            for (int i = 0; i < 4; i++) begin
               q_ff[i] <= VIDX_WIDTH'((PRODW'(lane_v[i]) * PRODW'(RECIP_W)) >> RECIP_SHIFT);
            end
         end
         F_REM: begin
            for (int i = 0; i < 4; i++) begin
               r_ff[i] <= VIDX_WIDTH'(RMW'(lane_v[i]) - RMW'(q_ff[i]) * RMW'(MAXV));
            end
         end
         F_FIX: begin
            item_ff.vertex_index <= fix_v[0];
            item_ff.corner_a     <= fix_v[1];
            item_ff.corner_b     <= fix_v[2];
            item_ff.corner_c     <= fix_v[3];
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/vna_queue.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module vna_queue import vna_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  req_word_type push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output req_word_type pop_data
);

   localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   req_word_type    mem_ff [QUEUE_DEPTH];
   logic [PTRW-1:0] wr_ptr_ff;
   logic [PTRW-1:0] rd_ptr_ff;
   logic [CNTW-1:0] count_ff;
   logic            push;
   logic            pop;

   assign push_ready = (count_ff != CNTW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/vna_norm.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator normalize unit
// Scales one accumulated normal to unit length in Q1.14: range reduction by
// single-bit shifts, squares, a digit-by-digit square root and one shared
// restoring divider used for the three components in turn.
// ----------------------------------------------------------------------------
module vna_norm import vna_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  acc_vec_type           acc,
   input  logic [VIDX_WIDTH-1:0] vertex,
   output logic                  done,
   input  logic                  ack,
   output rsp_word_type          result
);

   localparam int MAGW  = 30;
   localparam int SQW   = 2 * MAGW;
   localparam int WW    = 64;
   localparam int RW    = 32;
   localparam int QBITS = 15;
   localparam int DVW   = 46;
   localparam int CNTW  = 4;
   localparam logic [QBITS-1:0] Q_ONE = QBITS'(16384);

   typedef enum logic [2:0] {
      N_IDLE, N_SHIFT, N_SQUARE, N_SUM, N_SQRT, N_DIVI, N_DIV, N_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [VIDX_WIDTH-1:0]  vertex_ff;
   logic                   zero_ff;
   logic                   neg_ff [3];
   logic [ACC_WIDTH-1:0]   mag_ff [3];
   logic [SQW-1:0]         sq_ff [3];
   logic [WW-1:0]          s_ff;
   logic [WW-1:0]          root_ff;
   logic [WW-1:0]          bit_ff;
   logic [1:0]             comp_ff;
   logic [CNTW-1:0]        cnt_ff;
   logic [DVW-1:0]         rem_ff;
   logic [DVW-1:0]         dv_ff;
   logic [QBITS-1:0]       q_ff;
   logic [FIELD_WIDTH-1:0] res_ff [3];

   logic [ACC_WIDTH-1:0]   acc_in [3];
   logic                   all_zero;
   logic                   big;
   logic [WW-1:0]          trial;
   logic [RW-1:0]          r_div;
   logic [ACC_WIDTH-1:0]   mag_sel;
   logic                   ge;
   logic [QBITS-1:0]       q_fin;
   logic [QBITS-1:0]       q_cl;
   logic [FIELD_WIDTH-1:0] res_val;

   assign acc_in[0] = acc.x;
   assign acc_in[1] = acc.y;
   assign acc_in[2] = acc.z;
   assign all_zero  = (acc.x == '0) && (acc.y == '0) && (acc.z == '0);

   // Any magnitude at or above 2^30 still needs one more bit of right shift.
   assign big = (|mag_ff[0][ACC_WIDTH-1:MAGW]) || (|mag_ff[1][ACC_WIDTH-1:MAGW]) ||
                (|mag_ff[2][ACC_WIDTH-1:MAGW]);

   assign trial   = root_ff + bit_ff;
   assign r_div   = (root_ff == '0) ? RW'(1) : root_ff[RW-1:0];
   assign mag_sel = mag_ff[comp_ff];
   assign ge      = (rem_ff >= dv_ff);
   assign q_fin   = {q_ff[QBITS-2:0], ge};
   assign q_cl    = (q_fin > Q_ONE) ? Q_ONE : q_fin;
   assign res_val = neg_ff[comp_ff] ? (FIELD_WIDTH'(0) - FIELD_WIDTH'(q_cl))
                                    : FIELD_WIDTH'(q_cl);

   assign done               = (state_ff == N_DONE);
   assign result.out_vertex  = vertex_ff;
   assign result.norm_x      = res_ff[0];
   assign result.norm_y      = res_ff[1];
   assign result.norm_z      = res_ff[2];
   assign result.is_zero     = zero_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               state_in = all_zero ? N_DONE : N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (!big) begin
               state_in = N_SQUARE;
            end
         end
         N_SQUARE: state_in = N_SUM;
         N_SUM:    state_in = N_SQRT;
         N_SQRT: begin
            if (bit_ff[0]) begin
               state_in = N_DIVI;
            end
         end
         N_DIVI:   state_in = N_DIV;
         N_DIV: begin
            if (cnt_ff == CNTW'(QBITS - 1)) begin
               state_in = (comp_ff == 2'd2) ? N_DONE : N_DIVI;
            end
         end
         N_DONE: begin
            if (ack) begin
               state_in = N_IDLE;
            end
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               vertex_ff <= vertex;
               zero_ff   <= all_zero;
               comp_ff   <= 2'd0;
               for (int i = 0; i < 3; i++) begin
                  neg_ff[i] <= acc_in[i][ACC_WIDTH-1];
                  mag_ff[i] <= acc_in[i][ACC_WIDTH-1] ? (ACC_WIDTH'(0) - acc_in[i])
                                                      : acc_in[i];
                  res_ff[i] <= '0;
               end
            end
         end
         N_SHIFT: begin
            if (big) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
            end
         end
         N_SQUARE: begin
            for (int i = 0; i < 3; i++) begin
               sq_ff[i] <= SQW'(mag_ff[i][MAGW-1:0]) * SQW'(mag_ff[i][MAGW-1:0]);
            end
         end
         N_SUM: begin
            s_ff    <= WW'(sq_ff[0]) + WW'(sq_ff[1]) + WW'(sq_ff[2]);
            root_ff <= '0;
            bit_ff  <= WW'(1) << 62;
         end
         N_SQRT: begin
            if (s_ff >= trial) begin
               s_ff    <= s_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         N_DIVI: begin
            // Numerator carries the half-divisor so the quotient rounds to nearest.
            rem_ff <= (DVW'(mag_sel[MAGW-1:0]) << 14) + DVW'(r_div >> 1);
            dv_ff  <= DVW'(r_div) << (QBITS - 1);
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         N_DIV: begin
            if (ge) begin
               rem_ff <= rem_ff - dv_ff;
            end
            dv_ff  <= dv_ff >> 1;
            q_ff   <= q_fin;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(QBITS - 1)) begin
               res_ff[comp_ff] <= res_val;
               if (comp_ff != 2'd2) begin
                  comp_ff <= comp_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/vna_back.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator back end
// Executes queued words against the position and accumulator memories,
// forms face normals, runs read-modify-write on the accumulators and drives
// the response register.
// ----------------------------------------------------------------------------
module vna_back import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int POS_WIDTH    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   output logic         q_ready,
   input  req_word_type q_data,
   vna_rsp_if.source    rsp
);

   localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int PRW = 3 * POS_WIDTH;
   localparam int DW  = POS_WIDTH + 1;
   localparam int PW  = 2 * DW;
   localparam int NW  = (PW + 1 > ACC_WIDTH) ? PW + 1 : ACC_WIDTH;
   localparam int ARW = 3 * ACC_WIDTH;

   typedef enum logic [3:0] {
      B_IDLE, B_LOAD, B_PA, B_PB, B_PC, B_DIFF, B_MUL, B_SUM,
      B_ACC_RD, B_ACC_WR, B_RD0, B_RD1, B_WAIT
   } state_type;

   state_type             state_ff, state_in;
   req_word_type          item_ff;
   logic [1:0]            k_ff;
   logic [PRW-1:0]        pa_ff;
   logic [PRW-1:0]        pb_ff;
   logic signed [DW-1:0]  d_ff [6];
   logic signed [PW-1:0]  p_ff [6];
   logic [ACC_WIDTH-1:0]  n_ff [3];

   logic [PRW-1:0]        pos_mem_ff [MAX_VERTICES];
   logic [ARW-1:0]        acc_mem_ff [MAX_VERTICES];
   logic [PRW-1:0]        pos_rd_ff;
   logic [ARW-1:0]        acc_rd_ff;

   logic                  pos_we;
   logic [AW-1:0]         pos_raddr;
   logic [PRW-1:0]        pos_wdata;
   logic                  acc_we;
   logic [AW-1:0]         acc_waddr;
   logic [AW-1:0]         acc_raddr;
   logic [ARW-1:0]        acc_wdata;
   logic [VIDX_WIDTH-1:0] corner [3];

   logic                  norm_start;
   logic                  norm_done;
   logic                  norm_ack;
   acc_vec_type           norm_acc;
   rsp_word_type          norm_result;

   logic                  rsp_valid_ff;
   rsp_word_type          rsp_data_ff;
   logic                  out_free;

   function automatic logic signed [POS_WIDTH-1:0] coord(input logic [PRW-1:0] w,
                                                          input int k);
      return w[k*POS_WIDTH +: POS_WIDTH];
   endfunction

   assign corner[0] = item_ff.corner_a;
   assign corner[1] = item_ff.corner_b;
   assign corner[2] = item_ff.corner_c;

   assign q_ready    = (state_ff == B_IDLE);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign norm_start = (state_ff == B_RD1);
   assign norm_ack   = (state_ff == B_WAIT) && norm_done && out_free;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.data   = rsp_data_ff;

   assign norm_acc.x = acc_rd_ff[ACC_WIDTH-1:0];
   assign norm_acc.y = acc_rd_ff[2*ACC_WIDTH-1:ACC_WIDTH];
   assign norm_acc.z = acc_rd_ff[ARW-1:2*ACC_WIDTH];

   // The low POS_WIDTH bits of each raw field are kept and read back as signed.
   assign pos_wdata = {POS_WIDTH'($unsigned(item_ff.pos_z)),
                       POS_WIDTH'($unsigned(item_ff.pos_y)),
                       POS_WIDTH'($unsigned(item_ff.pos_x))};
   assign pos_we    = (state_ff == B_LOAD);

   always_comb begin
      pos_raddr = AW'(item_ff.corner_a);
      acc_raddr = AW'(item_ff.vertex_index);
      acc_we    = 1'b0;
      acc_waddr = AW'(item_ff.vertex_index);
      acc_wdata = '0;
      case (state_ff)
         B_PB:     pos_raddr = AW'(item_ff.corner_b);
         B_PC:     pos_raddr = AW'(item_ff.corner_c);
         B_ACC_RD: acc_raddr = AW'(corner[k_ff]);
         B_LOAD:   acc_we    = 1'b1;
         B_ACC_WR: begin
            acc_we    = 1'b1;
            acc_waddr = AW'(corner[k_ff]);
            acc_wdata = {acc_rd_ff[ARW-1:2*ACC_WIDTH] + n_ff[2],
                         acc_rd_ff[2*ACC_WIDTH-1:ACC_WIDTH] + n_ff[1],
                         acc_rd_ff[ACC_WIDTH-1:0] + n_ff[0]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem_ff[AW'(item_ff.vertex_index)] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem_ff[pos_raddr];
      if (acc_we) begin
         acc_mem_ff[acc_waddr] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem_ff[acc_raddr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               case (q_data.opcode)
                  OP_LOAD:     state_in = B_LOAD;
                  OP_TRIANGLE: state_in = B_PA;
                  OP_READ:     state_in = B_RD0;
                  default:     state_in = B_IDLE;
               endcase
            end
         end
         B_LOAD:   state_in = B_IDLE;
         B_PA:     state_in = B_PB;
         B_PB:     state_in = B_PC;
         B_PC:     state_in = B_DIFF;
         B_DIFF:   state_in = B_MUL;
         B_MUL:    state_in = B_SUM;
         B_SUM:    state_in = B_ACC_RD;
         B_ACC_RD: state_in = B_ACC_WR;
         B_ACC_WR: state_in = (k_ff == 2'd2) ? B_IDLE : B_ACC_RD;
         B_RD0:    state_in = B_RD1;
         B_RD1:    state_in = B_WAIT;
         B_WAIT: begin
            if (norm_ack) begin
               state_in = B_IDLE;
            end
         end
         default:  state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (norm_ack) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (norm_ack) begin
         rsp_data_ff <= norm_result;
      end
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               item_ff <= q_data;
            end
            k_ff <= 2'd0;
         end
         B_PB: pa_ff <= pos_rd_ff;
         B_PC: pb_ff <= pos_rd_ff;
         B_DIFF: begin
            // Edge vectors b-a and c-a; the read data now holds corner c.
            for (int i = 0; i < 3; i++) begin
               d_ff[i]     <= DW'(coord(pb_ff, i)) - DW'(coord(pa_ff, i));
               d_ff[i + 3] <= DW'(coord(pos_rd_ff, i)) - DW'(coord(pa_ff, i));
            end
         end
         B_MUL: begin
            p_ff[0] <= PW'(d_ff[1]) * PW'(d_ff[5]);
            p_ff[1] <= PW'(d_ff[2]) * PW'(d_ff[4]);
            p_ff[2] <= PW'(d_ff[2]) * PW'(d_ff[3]);
            p_ff[3] <= PW'(d_ff[0]) * PW'(d_ff[5]);
            p_ff[4] <= PW'(d_ff[0]) * PW'(d_ff[4]);
            p_ff[5] <= PW'(d_ff[1]) * PW'(d_ff[3]);
         end
         B_SUM: begin
            for (int i = 0; i < 3; i++) begin
               n_ff[i] <= ACC_WIDTH'(NW'(p_ff[2*i]) - NW'(p_ff[2*i + 1]));
            end
         end
         B_ACC_WR: k_ff <= k_ff + 1'b1;
         default: begin
         end
      endcase
   end

   vna_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .acc    (norm_acc),
      .vertex (item_ff.vertex_index),
      .done   (norm_done),
      .ack    (norm_ack),
      .result (norm_result)
   );

endmodule
